/* rtl/rde_pkg.sv */
package rde_pkg;

    // item and register geometry
    localparam int IN_W          = 32;
    localparam int DIGIT_W       = 6;
    localparam int DEF_VALUE_W   = 32;
    localparam int PADDR_W       = 3;
    localparam int PDATA_W       = 32;

    // base register limits and reset value
    localparam logic [DIGIT_W-1:0] BASE_MIN   = 6'd2;
    localparam logic [DIGIT_W-1:0] BASE_MAX   = 6'd36;
    localparam logic [DIGIT_W-1:0] BASE_RESET = 6'd10;

    // register index of the base register
    localparam logic REG_BASE = 1'b0;

    // back-end sequencer states
    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIV,
        BK_EMIT
    } bk_state_t;

    // divider status seen by the back end
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

/* rtl/rde_front.sv */
module rde_front #(
    parameter int VALUE_WIDTH = rde_pkg::DEF_VALUE_W
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic [rde_pkg::DIGIT_W-1:0] base_cfg,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [rde_pkg::IN_W-1:0]    s_value,
    output logic                        q_valid,
    input  logic                        q_ready,
    output logic [VALUE_WIDTH-1:0]      q_value,
    output logic [rde_pkg::DIGIT_W-1:0] q_base
);
    import rde_pkg::*;

    logic [VALUE_WIDTH-1:0] value_mem [2];
    logic [DIGIT_W-1:0]     base_mem  [2];
    logic                   wr_ptr_reg, wr_ptr_next;
    logic                   rd_ptr_reg, rd_ptr_next;
    logic [1:0]             count_reg, count_next;
    logic                   push, pop;
    logic [VALUE_WIDTH-1:0] value_cls;
    logic [DIGIT_W-1:0]     base_cls;

    // classify: mask value to the working width, clamp base into range
    assign value_cls = VALUE_WIDTH'(s_value);

    always_comb begin
        if (base_cfg < BASE_MIN) begin
            base_cls = BASE_MIN;
        end else if (base_cfg > BASE_MAX) begin
            base_cls = BASE_MAX;
        end else begin
            base_cls = base_cfg;
        end
    end

    // two-entry queue toward the back end
    assign s_ready = (count_reg != 2'd2);
    assign q_valid = (count_reg != 2'd0);
    assign push    = s_valid && s_ready;
    assign pop     = q_valid && q_ready;
    assign q_value = value_mem[rd_ptr_reg];
    assign q_base  = base_mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            value_mem[wr_ptr_reg] <= value_cls;
            base_mem[wr_ptr_reg]  <= base_cls;
        end
    end

    // queue occupancy and queued-base range assertions
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg != 2'd3)
        else $error("queue count out of range");

    a_base_clamped: assert property (@(posedge aclk) disable iff (!aresetn)
        q_valid |-> (q_base >= BASE_MIN && q_base <= BASE_MAX))
        else $error("queued base outside range");

endmodule

/* rtl/rde_div.sv */
module rde_div #(
    parameter int VALUE_WIDTH = rde_pkg::DEF_VALUE_W
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [VALUE_WIDTH-1:0]      dividend,
    input  logic [rde_pkg::DIGIT_W-1:0] divisor,
    output rde_pkg::div_stat_t          stat,
    output logic [VALUE_WIDTH-1:0]      quotient,
    output logic [rde_pkg::DIGIT_W-1:0] remainder
);
    import rde_pkg::*;

    localparam int CW = $clog2(VALUE_WIDTH + 1);

    logic [VALUE_WIDTH-1:0] quo_reg, quo_next;
    logic [DIGIT_W-1:0]     rem_reg, rem_next;
    logic [DIGIT_W-1:0]     dvs_reg;
    logic [CW-1:0]          cnt_reg, cnt_next;
    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    logic [DIGIT_W:0]       trial;
    logic [DIGIT_W:0]       diff;
    logic                   ge;

    // one restoring step: bring in the next dividend bit, subtract if it fits
    assign trial = {rem_reg, quo_reg[VALUE_WIDTH-1]};
    assign ge    = (trial >= {1'b0, dvs_reg});
    assign diff  = trial - {1'b0, dvs_reg};

    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            quo_next  = dividend;
            rem_next  = '0;
            cnt_next  = CW'(VALUE_WIDTH);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            quo_next = {quo_reg[VALUE_WIDTH-2:0], ge};
            rem_next = ge ? diff[DIGIT_W-1:0] : trial[DIGIT_W-1:0];
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        if (start) begin
            dvs_reg <= divisor;
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

    // divider sanity
    a_rem_below_divisor: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> (rem_reg < dvs_reg))
        else $error("remainder not below divisor");

    a_done_not_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> !busy_reg)
        else $error("divider done while still busy");

endmodule

/* rtl/rde_back.sv */
module rde_back #(
    parameter int VALUE_WIDTH = rde_pkg::DEF_VALUE_W
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        q_valid,
    output logic                        q_ready,
    input  logic [VALUE_WIDTH-1:0]      q_value,
    input  logic [rde_pkg::DIGIT_W-1:0] q_base,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [rde_pkg::DIGIT_W-1:0] m_digit,
    output logic                        m_last
);
    import rde_pkg::*;

    localparam int PW = $clog2(VALUE_WIDTH + 1);
    localparam int AW = $clog2(VALUE_WIDTH);

    bk_state_t              state_reg, state_next;
    logic [PW-1:0]          sp_reg, sp_next;
    logic [DIGIT_W-1:0]     base_reg;
    logic                   m_valid_reg;
    logic [DIGIT_W-1:0]     m_digit_reg;
    logic                   m_last_reg;
    logic [DIGIT_W-1:0]     stack_mem [VALUE_WIDTH];
    logic [PW-1:0]          rd_ptr;

    div_stat_t              div_st;
    logic                   div_start;
    logic [VALUE_WIDTH-1:0] div_dividend;
    logic [DIGIT_W-1:0]     div_divisor;
    logic [VALUE_WIDTH-1:0] div_quo;
    logic [DIGIT_W-1:0]     div_rem;

    logic                   finish;
    logic                   push, pop;

    rde_div #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .stat      (div_st),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // no more digits once the quotient runs out or the stack is full
    assign finish = (div_quo == '0) || (sp_reg == PW'(VALUE_WIDTH - 1));

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE: begin
                if (q_valid) begin
                    state_next = BK_DIV;
                end
            end
            BK_DIV: begin
                if (div_st.done && finish) begin
                    state_next = BK_EMIT;
                end
            end
            BK_EMIT: begin
                if (pop && sp_reg == PW'(1)) begin
                    state_next = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        q_ready   = 1'b0;
        div_start = 1'b0;
        push      = 1'b0;
        pop       = 1'b0;
        unique case (state_reg)
            BK_IDLE: begin
                q_ready   = 1'b1;
                div_start = q_valid;
            end
            BK_DIV: begin
                push      = div_st.done;
                div_start = div_st.done && !finish;
            end
            BK_EMIT: begin
                pop = (sp_reg != '0) && (!m_valid_reg || m_ready);
            end
            default: begin
                q_ready = 1'b0;
            end
        endcase
    end

    // first division takes the fresh item, later ones the running quotient
    assign div_dividend = (state_reg == BK_IDLE) ? q_value : div_quo;
    assign div_divisor  = (state_reg == BK_IDLE) ? q_base : base_reg;

    // digit stack pointer
    always_comb begin
        sp_next = sp_reg;
        if (push) begin
            sp_next = sp_reg + PW'(1);
        end else if (pop) begin
            sp_next = sp_reg - PW'(1);
        end
    end

    assign rd_ptr = sp_reg - PW'(1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= BK_IDLE;
            sp_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            sp_reg    <= sp_next;
            if (pop) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // stack write, registered read into the output stage
    always_ff @(posedge aclk) begin
        if (push) begin
            stack_mem[sp_reg[AW-1:0]] <= div_rem;
        end
        if (pop) begin
            m_digit_reg <= stack_mem[rd_ptr[AW-1:0]];
            m_last_reg  <= (sp_reg == PW'(1));
        end
        if (state_reg == BK_IDLE && q_valid) begin
            base_reg <= q_base;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_digit = m_digit_reg;
    assign m_last  = m_last_reg;

    // sequencer checks
    a_emit_has_digits: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == BK_EMIT |-> sp_reg != '0)
        else $error("emitting with empty digit stack");

    a_start_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> !div_st.busy)
        else $error("divider restarted while busy");

    a_digit_below_base: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> m_digit_reg < base_reg)
        else $error("digit not below base");

endmodule

/* rtl/radix_digit_emitter.sv */
// the first digit of an item leaves once all its divisions are done; digits then
//   leave one per cycle while m_ready is held; a new item is taken only after
//   the last digit of the previous one has left the stack; divisions run on the
//   shared bit-serial divider (one quotient bit per cycle, one division per digit)
// reset: base register to 10, input queue empty, no digit pending
module radix_digit_emitter #(
    parameter int VALUE_WIDTH = rde_pkg::DEF_VALUE_W
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [rde_pkg::PADDR_W-1:0] paddr,
    input  logic [rde_pkg::PDATA_W-1:0] pwdata,
    output logic [rde_pkg::PDATA_W-1:0] prdata,
    output logic                        pready,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [rde_pkg::IN_W-1:0]    s_value,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [rde_pkg::DIGIT_W-1:0] m_digit,
    output logic                        m_last
);
    import rde_pkg::*;

    logic [DIGIT_W-1:0]     base_reg;
    logic                   cfg_wr;
    logic                   q_valid, q_ready;
    logic [VALUE_WIDTH-1:0] q_value;
    logic [DIGIT_W-1:0]     q_base;

    // register port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg <= BASE_RESET;
        end else if (cfg_wr && paddr[2] == REG_BASE) begin
            base_reg <= pwdata[DIGIT_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_BASE) begin
            prdata = PDATA_W'(base_reg);
        end
    end

    rde_front #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .base_cfg (base_reg),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_value  (s_value),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_value  (q_value),
        .q_base   (q_base)
    );

    rde_back #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_value (q_value),
        .q_base  (q_base),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_digit (m_digit),
        .m_last  (m_last)
    );

endmodule
